@@ rtl/mh64_pkg.sv @@
// mh64_pkg: shared constants for the 64-bit murmur hash block
// no dependencies; used by the interfaces, the multiplier and the top level

package mh64_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 32;

    // mixing constant and its halves for the 32x32 partial products
    localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam logic [HALF_W-1:0] MIX_MUL_LO = 32'h5bd1e995;
    localparam logic [HALF_W-1:0] MIX_MUL_HI = 32'hc6a4a793;
    localparam int                MIX_SHIFT  = 47;

    // byte count of a full word
    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

endpackage

@@ rtl/mh64_if.sv @@
// mh64_if: valid/ready channel interfaces for message words and hash results
// depends on mh64_pkg for field widths

interface mh64_in_if;
    logic                             valid;
    logic                             ready;
    logic [mh64_pkg::WORD_W-1:0]      data_word;
    logic [mh64_pkg::COUNT_W-1:0]     byte_count;
    logic                             first_item;
    logic                             last_item;
    logic [mh64_pkg::LEN_W-1:0]       message_length;

    modport source (
        output valid, data_word, byte_count, first_item, last_item, message_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_item, last_item, message_length,
        output ready
    );
endinterface

interface mh64_out_if;
    logic                        valid;
    logic                        ready;
    logic [mh64_pkg::WORD_W-1:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

@@ rtl/mh64_mul.sv @@
// mh64_mul: multiplies a 64-bit operand by the mixing constant modulo 2^64
// one 32x32 multiplier, three partial products computed one after another
// depends on mh64_pkg

module mh64_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mh64_pkg::WORD_W-1:0] operand,
    output logic                        done,
    output logic [mh64_pkg::WORD_W-1:0] product
);

    typedef enum logic [1:0] {
        STEP_LO,
        STEP_CROSS_A,
        STEP_CROSS_B
    } step_t;

    step_t                        step_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [mh64_pkg::WORD_W-1:0]  a_reg;
    logic [mh64_pkg::WORD_W-1:0]  acc_reg;
    logic [mh64_pkg::WORD_W-1:0]  acc_next;
    logic [mh64_pkg::HALF_W-1:0]  mul_x;
    logic [mh64_pkg::HALF_W-1:0]  mul_y;
    logic [mh64_pkg::WORD_W-1:0]  part;

    // operand halves for the current partial product
    always_comb
    begin
        case (step_reg)
            STEP_LO:
            begin
                mul_x = a_reg[mh64_pkg::HALF_W-1:0];
                mul_y = mh64_pkg::MIX_MUL_LO;
            end
            STEP_CROSS_A:
            begin
                mul_x = a_reg[mh64_pkg::WORD_W-1:mh64_pkg::HALF_W];
                mul_y = mh64_pkg::MIX_MUL_LO;
            end
            STEP_CROSS_B:
            begin
                mul_x = a_reg[mh64_pkg::HALF_W-1:0];
                mul_y = mh64_pkg::MIX_MUL_HI;
            end
            default:
            begin
                mul_x = a_reg[mh64_pkg::HALF_W-1:0];
                mul_y = mh64_pkg::MIX_MUL_LO;
            end
        endcase
    end

    // shared 32x32 multiplier
    assign part = {{mh64_pkg::HALF_W{1'b0}}, mul_x} * {{mh64_pkg::HALF_W{1'b0}}, mul_y};

    // low product loads, cross products add into the upper half
    always_comb
    begin
        if (step_reg == STEP_LO)
        begin
            acc_next = part;
        end
        else
        begin
            acc_next = acc_reg + {part[mh64_pkg::HALF_W-1:0], {mh64_pkg::HALF_W{1'b0}}};
        end
    end

    // step sequencing and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LO;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            a_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= operand;
                step_reg <= STEP_LO;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                case (step_reg)
                    STEP_LO:      step_reg <= STEP_CROSS_A;
                    STEP_CROSS_A: step_reg <= STEP_CROSS_B;
                    STEP_CROSS_B:
                    begin
                        step_reg <= STEP_LO;
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    default:      step_reg <= STEP_LO;
                endcase
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/murmur2_hash64.sv @@
// murmur2_hash64: streaming 64-bit murmur hash over little-endian message words
// depends on mh64_pkg, mh64_in_if / mh64_out_if and mh64_mul
//
//   channel   direction  contents
//   in_ch     sink       data_word, byte_count, first_item, last_item, message_length
//   out_ch    source     hash_value, one per item marked last
//   seed_*    write      seed register, write enable and data, no read-back
//
// every multiplication by the mixing constant runs on the shared 32x32 multiplier; an
// item needs n multiplications before the input is ready again, n = 3 for a full word,
// 1 for a partial word, 0 for an empty one, plus 1 on a first item, plus 1 on a last
// item (final mix), which then also loads the output register
// reset clears the seed and the running hash; a result waiting in the output
// register stalls the block only when the next result is ready to load

module murmur2_hash64 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_we,
    input  logic [mh64_pkg::WORD_W-1:0] seed_wdata,
    mh64_in_if.sink                     in_ch,
    mh64_out_if.source                  out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_WORD,
        ST_KEY1,
        ST_KEY2,
        ST_HASH,
        ST_FIN,
        ST_FINAL,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    logic [mh64_pkg::WORD_W-1:0]     seed_reg;
    logic [mh64_pkg::WORD_W-1:0]     hash_reg;
    logic [mh64_pkg::WORD_W-1:0]     word_reg;
    logic [mh64_pkg::COUNT_W-1:0]    count_reg;
    logic                            last_reg;
    logic                            mul_start_reg;
    logic [mh64_pkg::WORD_W-1:0]     mul_operand_reg;
    logic                            out_valid_reg;
    logic [mh64_pkg::WORD_W-1:0]     out_hash_reg;

    logic                            mul_done;
    logic [mh64_pkg::WORD_W-1:0]     mul_product;
    logic [mh64_pkg::WORD_W-1:0]     byte_mask;
    logic [mh64_pkg::WORD_W-1:0]     partial_hash;
    logic [mh64_pkg::WORD_W-1:0]     key_mixed;
    logic [mh64_pkg::WORD_W-1:0]     key2_hash;
    logic [mh64_pkg::WORD_W-1:0]     fin_operand;
    logic [mh64_pkg::WORD_W-1:0]     final_hash;
    logic                            in_xfer;

    // shared constant multiplier
    mh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .operand (mul_operand_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // keep bytes below the byte count
    always_comb
    begin
        for (int i = 0; i < mh64_pkg::WORD_W / 8; i++)
        begin
            byte_mask[i*8 +: 8] = (count_reg > mh64_pkg::COUNT_W'(i)) ? 8'hff : 8'h00;
        end
    end

    // xor-shift and combine terms
    assign partial_hash = hash_reg ^ (word_reg & byte_mask);
    assign key_mixed    = mul_product ^ (mul_product >> mh64_pkg::MIX_SHIFT);
    assign key2_hash    = hash_reg ^ mul_product;
    assign fin_operand  = hash_reg ^ (hash_reg >> mh64_pkg::MIX_SHIFT);
    assign final_hash   = mul_product ^ (mul_product >> mh64_pkg::MIX_SHIFT);

    assign in_xfer = in_ch.valid && (state_reg == ST_IDLE);

    // sequencer, hash state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seed_reg        <= '0;
            hash_reg        <= '0;
            word_reg        <= '0;
            count_reg       <= '0;
            last_reg        <= 1'b0;
            mul_start_reg   <= 1'b0;
            mul_operand_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_hash_reg    <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;

            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end

            // result taken downstream, unless a new one loads in its place
            if (out_valid_reg && out_ch.ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        word_reg  <= in_ch.data_word;
                        count_reg <= in_ch.byte_count;
                        last_reg  <= in_ch.last_item;
                        if (in_ch.first_item)
                        begin
                            mul_operand_reg <= {{(mh64_pkg::WORD_W-mh64_pkg::LEN_W){1'b0}},
                                                in_ch.message_length};
                            mul_start_reg   <= 1'b1;
                            state_reg       <= ST_LEN;
                        end
                        else
                        begin
                            state_reg <= ST_WORD;
                        end
                    end
                end
                ST_LEN:
                begin
                    if (mul_done)
                    begin
                        hash_reg  <= seed_reg ^ mul_product;
                        state_reg <= ST_WORD;
                    end
                end
                ST_WORD:
                begin
                    if (count_reg >= mh64_pkg::FULL_COUNT)
                    begin
                        mul_operand_reg <= word_reg;
                        mul_start_reg   <= 1'b1;
                        state_reg       <= ST_KEY1;
                    end
                    else if (count_reg != '0)
                    begin
                        hash_reg        <= partial_hash;
                        mul_operand_reg <= partial_hash;
                        mul_start_reg   <= 1'b1;
                        state_reg       <= ST_HASH;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_KEY1:
                begin
                    if (mul_done)
                    begin
                        mul_operand_reg <= key_mixed;
                        mul_start_reg   <= 1'b1;
                        state_reg       <= ST_KEY2;
                    end
                end
                ST_KEY2:
                begin
                    if (mul_done)
                    begin
                        hash_reg        <= key2_hash;
                        mul_operand_reg <= key2_hash;
                        mul_start_reg   <= 1'b1;
                        state_reg       <= ST_HASH;
                    end
                end
                ST_HASH:
                begin
                    if (mul_done)
                    begin
                        hash_reg  <= mul_product;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (last_reg)
                    begin
                        mul_operand_reg <= fin_operand;
                        mul_start_reg   <= 1'b1;
                        state_reg       <= ST_FINAL;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FINAL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // load once the output register is free or being emptied
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_hash_reg  <= final_hash;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.hash_value = out_hash_reg;

endmodule
